// File: src/i2c_bitbang_master_macros.svh
// ----------------------------------------------------------------------------
// i2c bit-bang master assertion macros
// shared property forms for the i2c bit-bang master checks
// ----------------------------------------------------------------------------
`ifndef I2C_BITBANG_MASTER_MACROS_SVH
`define I2C_BITBANG_MASTER_MACROS_SVH

// same-cycle implication
`define I2CBB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2c bit-bang master check failed");

// next-cycle implication
`define I2CBB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2c bit-bang master check failed");

`endif

// File: src/i2cbb_pkg.sv
// ----------------------------------------------------------------------------
// i2cbb_pkg
// types and codes shared by the i2c bit-bang master
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cbb_pkg;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT    = 2'd1;
  localparam logic [1:0] CFG_WRITE_GAP      = 2'd2;
  localparam logic [1:0] CFG_READ_GAP       = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] cmd_length;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       sda_sample;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       tx_taken;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       done_res;
    logic       nak_seen;
    logic       busy_res;
  } res_t;

endpackage

// File: src/i2c_bitbang_master.sv
// ----------------------------------------------------------------------------
// i2c_bitbang_master
// i2c master that drives scl and sda one line tick per item
// ----------------------------------------------------------------------------
// usage:
//   req channel (req_valid, req_stall, req_data): one item per line tick,
//   carrying an optional write/read command, tx data and the sampled sda.
//   res channel (res_valid, res_stall, res_data): one item per accepted tick
//   with the scl/sda levels, sda drive enable and transfer status.
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data): register writes,
//   always ready; to be issued only while no transfer items are in flight,
//   which the block itself does not enforce. An accepted item is held in
//   the input register and its result is registered in the result register.
// throughput: one item per cycle when not stalled; the tick step is a single
//   pass of the phase logic between the input and result registers.
// reset: phase idle, scl and sda high with sda driven, registers at their
//   defaults (address 0, timeout 5, write gap 5, read gap 3).
// stall: while res_stall holds a full result register a full input register
//   holds too and req_stall rises; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_bitbang_master_macros.svh"

module i2c_bitbang_master (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  i2cbb_pkg::req_t  req_data,
  output logic             res_valid,
  input  logic             res_stall,
  output i2cbb_pkg::res_t  res_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data
);

  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_TX_LOW   = 5'd1;
  localparam logic [4:0] PH_TX_SET   = 5'd2;
  localparam logic [4:0] PH_TX_HIGH  = 5'd3;
  localparam logic [4:0] PH_TX_HOLD  = 5'd4;
  localparam logic [4:0] PH_ACK_LOW  = 5'd5;
  localparam logic [4:0] PH_ACK_WAIT = 5'd6;
  localparam logic [4:0] PH_GAP      = 5'd7;
  localparam logic [4:0] PH_LOAD     = 5'd8;
  localparam logic [4:0] PH_RX_LOW   = 5'd9;
  localparam logic [4:0] PH_RX_HIGH  = 5'd10;
  localparam logic [4:0] PH_RA_LOW   = 5'd11;
  localparam logic [4:0] PH_RA_SET   = 5'd12;
  localparam logic [4:0] PH_RA_HIGH  = 5'd13;
  localparam logic [4:0] PH_RA_END   = 5'd14;
  localparam logic [4:0] PH_SP_LOW   = 5'd15;
  localparam logic [4:0] PH_SP_SDA0  = 5'd16;
  localparam logic [4:0] PH_SP_HIGH  = 5'd17;
  localparam logic [4:0] PH_SP_SDA1  = 5'd18;

  logic [6:0] device_address;
  logic [7:0] ack_timeout_ticks;
  logic [7:0] write_gap_ticks;
  logic [7:0] read_gap_ticks;

  logic [4:0] phase, phase_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] wait_count, wait_count_next;
  logic       is_read, is_read_next;
  logic       scl_reg, scl_reg_next;
  logic       sda_reg, sda_reg_next;
  logic       sda_dir, sda_dir_next;
  logic       addr_stage, addr_stage_next;

  logic            s1_valid;
  i2cbb_pkg::req_t s1_data;
  logic            adv;
  i2cbb_pkg::res_t step_res;

  logic [7:0] gap;
  logic [7:0] wait_inc;
  logic [7:0] bytes_dec;
  logic       taken, rxv, done, nak, busy;

  assign cfg_ready = 1'b1;
  assign adv       = s1_valid && (!res_valid || !res_stall);
  assign req_stall = s1_valid && !adv;

  assign gap       = is_read ? read_gap_ticks : write_gap_ticks;
  assign wait_inc  = (wait_count != 8'hFF) ? 8'(wait_count + 8'd1) : wait_count;
  assign bytes_dec = 8'(bytes_left - 8'd1);

  always_comb begin
    phase_next      = phase;
    bit_index_next  = bit_index;
    bytes_left_next = bytes_left;
    shift_reg_next  = shift_reg;
    wait_count_next = wait_count;
    is_read_next    = is_read;
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    sda_dir_next    = sda_dir;
    addr_stage_next = addr_stage;
    taken = 1'b0;
    rxv   = 1'b0;
    done  = 1'b0;
    nak   = 1'b0;
    busy  = 1'b1;
    case (phase)
      PH_IDLE: begin
        if (s1_data.req_type == i2cbb_pkg::REQ_WRITE ||
            s1_data.req_type == i2cbb_pkg::REQ_READ) begin
          is_read_next    = (s1_data.req_type == i2cbb_pkg::REQ_READ);
          bytes_left_next = s1_data.cmd_length;
          shift_reg_next  = {device_address, (s1_data.req_type == i2cbb_pkg::REQ_READ)};
          bit_index_next  = 3'd7;
          wait_count_next = 8'd0;
          sda_dir_next    = 1'b1;
          sda_reg_next    = 1'b0;
          addr_stage_next = 1'b1;
          phase_next      = PH_TX_LOW;
        end else begin
          busy = 1'b0;
        end
      end
      PH_TX_LOW: begin
        scl_reg_next = 1'b0;
        phase_next   = PH_TX_SET;
      end
      PH_TX_SET: begin
        sda_dir_next = 1'b1;
        sda_reg_next = shift_reg[7];
        phase_next   = PH_TX_HIGH;
      end
      PH_TX_HIGH: begin
        scl_reg_next = 1'b1;
        phase_next   = PH_TX_HOLD;
      end
      PH_TX_HOLD: begin
        sda_reg_next   = shift_reg[7];
        shift_reg_next = {shift_reg[6:0], 1'b0};
        if (bit_index == 3'd0) begin
          phase_next = PH_ACK_LOW;
        end else begin
          bit_index_next = 3'(bit_index - 3'd1);
          phase_next     = PH_TX_LOW;
        end
      end
      PH_ACK_LOW: begin
        scl_reg_next    = 1'b0;
        wait_count_next = 8'd0;
        phase_next      = PH_ACK_WAIT;
      end
      PH_ACK_WAIT: begin
        scl_reg_next = 1'b1;
        sda_dir_next = 1'b0;
        if (!s1_data.sda_sample) begin
          if (addr_stage) begin
            addr_stage_next = 1'b0;
            if (gap == 8'd0) begin
              if (bytes_left == 8'd0) begin
                phase_next = PH_SP_LOW;
              end else if (is_read) begin
                bit_index_next = 3'd7;
                shift_reg_next = 8'd0;
                phase_next     = PH_RX_LOW;
              end else begin
                phase_next = PH_LOAD;
              end
            end else begin
              wait_count_next = 8'd0;
              phase_next      = PH_GAP;
            end
          end else begin
            bytes_left_next = bytes_dec;
            phase_next      = (bytes_dec == 8'd0) ? PH_SP_LOW : PH_LOAD;
          end
        end else begin
          wait_count_next = wait_inc;
          if (wait_inc >= ack_timeout_ticks) begin
            done            = 1'b1;
            nak             = 1'b1;
            addr_stage_next = 1'b0;
            phase_next      = PH_IDLE;
          end
        end
      end
      PH_GAP: begin
        wait_count_next = wait_inc;
        if (wait_inc >= gap) begin
          if (bytes_left == 8'd0) begin
            phase_next = PH_SP_LOW;
          end else if (is_read) begin
            bit_index_next = 3'd7;
            shift_reg_next = 8'd0;
            phase_next     = PH_RX_LOW;
          end else begin
            phase_next = PH_LOAD;
          end
        end
      end
      PH_LOAD: begin
        if (s1_data.tx_valid) begin
          taken          = 1'b1;
          shift_reg_next = s1_data.tx_byte;
          bit_index_next = 3'd7;
          scl_reg_next   = 1'b0;
          phase_next     = PH_TX_SET;
        end
      end
      PH_RX_LOW: begin
        sda_dir_next = 1'b0;
        scl_reg_next = 1'b0;
        phase_next   = PH_RX_HIGH;
      end
      PH_RX_HIGH: begin
        scl_reg_next   = 1'b1;
        shift_reg_next = {shift_reg[6:0], s1_data.sda_sample};
        if (bit_index == 3'd0) begin
          rxv        = 1'b1;
          phase_next = PH_RA_LOW;
        end else begin
          bit_index_next = 3'(bit_index - 3'd1);
          phase_next     = PH_RX_LOW;
        end
      end
      PH_RA_LOW: begin
        scl_reg_next = 1'b0;
        phase_next   = PH_RA_SET;
      end
      PH_RA_SET: begin
        sda_dir_next = 1'b1;
        sda_reg_next = (bytes_left <= 8'd1);
        phase_next   = PH_RA_HIGH;
      end
      PH_RA_HIGH: begin
        scl_reg_next = 1'b1;
        phase_next   = PH_RA_END;
      end
      PH_RA_END: begin
        scl_reg_next    = 1'b0;
        bytes_left_next = bytes_dec;
        if (bytes_dec == 8'd0) begin
          phase_next = PH_SP_LOW;
        end else begin
          bit_index_next = 3'd7;
          shift_reg_next = 8'd0;
          phase_next     = PH_RX_LOW;
        end
      end
      PH_SP_LOW: begin
        scl_reg_next = 1'b0;
        phase_next   = PH_SP_SDA0;
      end
      PH_SP_SDA0: begin
        sda_dir_next = 1'b1;
        sda_reg_next = 1'b0;
        phase_next   = PH_SP_HIGH;
      end
      PH_SP_HIGH: begin
        scl_reg_next = 1'b1;
        phase_next   = PH_SP_SDA1;
      end
      PH_SP_SDA1: begin
        sda_reg_next = 1'b1;
        done         = 1'b1;
        phase_next   = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
        busy       = 1'b0;
      end
    endcase
  end

  always_comb begin
    step_res.scl_level = scl_reg_next;
    step_res.sda_level = sda_reg_next;
    step_res.sda_drive = sda_dir_next;
    step_res.tx_taken  = taken;
    step_res.rx_byte   = rxv ? shift_reg_next : 8'd0;
    step_res.rx_valid  = rxv;
    step_res.done_res  = done;
    step_res.nak_seen  = nak;
    step_res.busy_res  = busy;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address    <= 7'd0;
      ack_timeout_ticks <= 8'd5;
      write_gap_ticks   <= 8'd5;
      read_gap_ticks    <= 8'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        i2cbb_pkg::CFG_DEVICE_ADDRESS: device_address    <= cfg_data[6:0];
        i2cbb_pkg::CFG_ACK_TIMEOUT:    ack_timeout_ticks <= cfg_data;
        i2cbb_pkg::CFG_WRITE_GAP:      write_gap_ticks   <= cfg_data;
        i2cbb_pkg::CFG_READ_GAP:       read_gap_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_index  <= 3'd0;
      bytes_left <= 8'd0;
      shift_reg  <= 8'd0;
      wait_count <= 8'd0;
      is_read    <= 1'b0;
      scl_reg    <= 1'b1;
      sda_reg    <= 1'b1;
      sda_dir    <= 1'b1;
      addr_stage <= 1'b0;
    end else if (adv) begin
      phase      <= phase_next;
      bit_index  <= bit_index_next;
      bytes_left <= bytes_left_next;
      shift_reg  <= shift_reg_next;
      wait_count <= wait_count_next;
      is_read    <= is_read_next;
      scl_reg    <= scl_reg_next;
      sda_reg    <= sda_reg_next;
      sda_dir    <= sda_dir_next;
      addr_stage <= addr_stage_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1_data <= req_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_data <= step_res;
    end
  end

  `I2CBB_ASSERT_SAME(a_nak_ends, res_valid && res_data.nak_seen, res_data.done_res)
  `I2CBB_ASSERT_SAME(a_take_scl_low, res_valid && res_data.tx_taken, !res_data.scl_level)
  `I2CBB_ASSERT_SAME(a_rx_scl_high, res_valid && res_data.rx_valid,
                     res_data.scl_level && !res_data.sda_drive)
  `I2CBB_ASSERT_NEXT(a_done_to_idle, adv && done, phase == PH_IDLE && !addr_stage)

endmodule
